/* design/crg_pkg.sv */
package crg_pkg;

  localparam int COMP_W     = 21;
  localparam int CFG_W      = 63;
  localparam int Q_W        = 32;
  localparam int UNIT_BITS  = 30;
  localparam int DEF_COORD_FRAC_BITS = 10;
  localparam int NUM_REGS   = 6;
  localparam int IDX_W      = 3;

  localparam logic [IDX_W-1:0] REG_CAM_POS = 3'd0;
  localparam logic [IDX_W-1:0] REG_LOOK_AT = 3'd1;
  localparam logic [IDX_W-1:0] REG_UP      = 3'd2;
  localparam logic [IDX_W-1:0] REG_FOCAL   = 3'd3;
  localparam logic [IDX_W-1:0] REG_WIDTH   = 3'd4;
  localparam logic [IDX_W-1:0] REG_ASPECT  = 3'd5;

  localparam logic [CFG_W-1:0] RST_CAM_POS = 63'd4376571674624;
  localparam logic [CFG_W-1:0] RST_LOOK_AT = 63'd0;
  localparam logic [CFG_W-1:0] RST_UP      = 63'd4503599627370496;
  localparam logic [Q_W-1:0]   RST_FOCAL   = 32'd65536;
  localparam logic [Q_W-1:0]   RST_WIDTH   = 32'd65536;
  localparam logic [Q_W-1:0]   RST_ASPECT  = 32'd65536;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD, ST_MAX, ST_SCALE, ST_SQ_MUL, ST_SQ_ACC, ST_SQRT,
    ST_DIV_LOAD, ST_DIV_RUN, ST_DIV_STORE, ST_NRM_DONE, ST_CR_MUL, ST_CR_ACC,
    ST_VS_LOAD, ST_VS_RUN, ST_VS_STORE, ST_FIN_MUL, ST_FIN_ACC
  } crg_state_t;

  typedef struct packed {
    logic [CFG_W-1:0] cam_pos;
    logic [CFG_W-1:0] look_at;
    logic [CFG_W-1:0] up_dir;
    logic [Q_W-1:0]   focal;
    logic [Q_W-1:0]   width;
    logic [Q_W-1:0]   aspect;
    logic             start;
  } crg_cfg_t;

  typedef struct packed {
    logic [2:0][Q_W-1:0] centre;
    logic [2:0][Q_W-1:0] hstep;
    logic [2:0][Q_W-1:0] vstep;
    logic                degenerate;
    logic                busy;
  } crg_basis_t;

  function automatic logic [Q_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end else begin
      return v[Q_W-1:0];
    end
  endfunction

  // sign-extended component of a packed vector
  function automatic logic signed [63:0] comp(input logic [CFG_W-1:0] pk,
                                              input logic [1:0] idx);
    logic [COMP_W-1:0] c;
    c = pk[COMP_W*idx +: COMP_W];
    return {{(64-COMP_W){c[COMP_W-1]}}, c};
  endfunction

endpackage

/* design/crg_basis.sv */
module crg_basis #(
  parameter int COORD_FRAC_BITS = crg_pkg::DEF_COORD_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  crg_pkg::crg_cfg_t   cfg,
  output crg_pkg::crg_basis_t basis
);
  import crg_pkg::*;

  localparam int SH = 16 - COORD_FRAC_BITS;

  crg_state_t state_r, state_nxt;

  logic signed [63:0] vec_r [3];
  logic        [63:0] mag_r;
  logic signed [31:0] f_r [3];
  logic signed [31:0] u_r [3];
  logic signed [31:0] v_r [3];
  logic               ok_r;
  logic        [1:0]  nsel_r;
  logic        [2:0]  step_r;
  logic        [6:0]  cnt_r;
  logic        [63:0] len2_r;
  logic        [63:0] rad_r;
  logic        [34:0] srem_r;
  logic        [31:0] root_r;
  logic        [63:0] dvd_r;
  logic        [31:0] dvs_r;
  logic        [31:0] drem_r;
  logic        [63:0] quo_r;
  logic signed [65:0] prod_r;
  logic        [31:0] vscale_r;
  logic [2:0][Q_W-1:0] centre_r, hstep_r, vstep_r;
  logic               deg_r;

  logic signed [32:0] mul_a, mul_b;
  logic        [63:0] vabs [3];
  logic        [63:0] mag_c;
  logic        [34:0] srem_sh, trial;
  logic        [32:0] drem_sh;
  logic               dbit;
  logic        [1:0]  ia, ib;
  logic        [1:0]  sidx;
  logic signed [65:0] scaled;

  assign sidx = step_r[1:0];

  function automatic logic signed [63:0] half_tz(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + $signed({63'b0, v[63]});
    return t >>> 1;
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vabs[i] = vec_r[i][63] ? 64'(-vec_r[i]) : 64'(vec_r[i]);
    end
    mag_c = vabs[0];
    if (vabs[1] > mag_c) mag_c = vabs[1];
    if (vabs[2] > mag_c) mag_c = vabs[2];
  end

  // one digit of square root and quotient per cycle
  always_comb begin
    srem_sh = {srem_r[32:0], rad_r[63:62]};
    trial   = {1'b0, root_r, 2'b01};
    drem_sh = {drem_r, dvd_r[63]};
    dbit    = drem_sh >= {1'b0, dvs_r};
  end

  // cross product term order: (1,2) (2,1) (2,0) (0,2) (0,1) (1,0)
  always_comb begin
    unique case (step_r)
      3'd0:    begin ia = 2'd1; ib = 2'd2; end
      3'd1:    begin ia = 2'd2; ib = 2'd1; end
      3'd2:    begin ia = 2'd2; ib = 2'd0; end
      3'd3:    begin ia = 2'd0; ib = 2'd2; end
      3'd4:    begin ia = 2'd0; ib = 2'd1; end
      default: begin ia = 2'd1; ib = 2'd0; end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      state_nxt = ST_IDLE;
      ST_LOAD:      state_nxt = ST_MAX;
      ST_MAX:       state_nxt = (mag_c == 64'd0) ? ST_NRM_DONE : ST_SCALE;
      ST_SCALE: begin
        if (mag_r[63:31] == '0 && mag_r[30]) state_nxt = ST_SQ_MUL;
      end
      ST_SQ_MUL:    state_nxt = ST_SQ_ACC;
      ST_SQ_ACC:    state_nxt = (step_r == 3'd2) ? ST_SQRT : ST_SQ_MUL;
      ST_SQRT:      state_nxt = (cnt_r == 7'd31) ? ST_DIV_LOAD : ST_SQRT;
      ST_DIV_LOAD:  state_nxt = ST_DIV_RUN;
      ST_DIV_RUN:   state_nxt = (cnt_r == 7'd63) ? ST_DIV_STORE : ST_DIV_RUN;
      ST_DIV_STORE: state_nxt = (step_r == 3'd2) ? ST_NRM_DONE : ST_DIV_LOAD;
      ST_NRM_DONE:  state_nxt = (nsel_r == 2'd2) ? ST_VS_LOAD : ST_CR_MUL;
      ST_CR_MUL:    state_nxt = ST_CR_ACC;
      ST_CR_ACC:    state_nxt = (step_r == 3'd5) ? ST_MAX : ST_CR_MUL;
      ST_VS_LOAD:   state_nxt = (cfg.aspect == '0) ? ST_FIN_MUL : ST_VS_RUN;
      ST_VS_RUN:    state_nxt = (cnt_r == 7'd63) ? ST_VS_STORE : ST_VS_RUN;
      ST_VS_STORE:  state_nxt = ST_FIN_MUL;
      ST_FIN_MUL:   state_nxt = ST_FIN_ACC;
      ST_FIN_ACC: begin
        if (cnt_r[1:0] == 2'd2 && step_r == 3'd2) state_nxt = ST_IDLE;
        else state_nxt = ST_FIN_MUL;
      end
      default:      state_nxt = ST_IDLE;
    endcase
    if (cfg.start) state_nxt = ST_LOAD;
  end

  // multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SQ_MUL: begin
        mul_a = vec_r[sidx][32:0];
        mul_b = vec_r[sidx][32:0];
      end
      ST_CR_MUL: begin
        if (nsel_r == 2'd1) begin
          mul_a = 33'(f_r[ia]);
          mul_b = 33'(comp(cfg.up_dir, ib));
        end else begin
          mul_a = 33'(u_r[ia]);
          mul_b = 33'(f_r[ib]);
        end
      end
      ST_FIN_MUL: begin
        unique case (cnt_r[1:0])
          2'd0:    begin mul_a = {1'b0, cfg.focal}; mul_b = 33'(f_r[sidx]); end
          2'd1:    begin mul_a = {1'b0, cfg.width}; mul_b = 33'(u_r[sidx]); end
          default: begin mul_a = {1'b0, vscale_r};  mul_b = 33'(v_r[sidx]); end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign scaled = prod_r >>> UNIT_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      deg_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FIN_ACC && state_nxt == ST_IDLE) deg_r <= !ok_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      ST_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          vec_r[i] <= comp(cfg.look_at, 2'(i)) - comp(cfg.cam_pos, 2'(i));
        end
        nsel_r <= 2'd0;
        ok_r   <= 1'b1;
      end
      ST_MAX: begin
        mag_r <= mag_c;
        if (mag_c == 64'd0) begin
          ok_r <= 1'b0;
          for (int i = 0; i < 3; i++) begin
            unique case (nsel_r)
              2'd0:    f_r[i] <= '0;
              2'd1:    u_r[i] <= '0;
              default: v_r[i] <= '0;
            endcase
          end
        end
      end
      ST_SCALE: begin
        step_r <= 3'd0;
        len2_r <= '0;
        if (mag_r[63:31] != '0) begin
          mag_r <= mag_r >> 1;
          for (int i = 0; i < 3; i++) vec_r[i] <= half_tz(vec_r[i]);
        end else if (!mag_r[30]) begin
          mag_r <= mag_r << 1;
          for (int i = 0; i < 3; i++) vec_r[i] <= vec_r[i] <<< 1;
        end
      end
      ST_SQ_ACC: begin
        len2_r <= len2_r + prod_r[63:0];
        rad_r  <= len2_r + prod_r[63:0];
        step_r <= step_r + 3'd1;
        srem_r <= '0;
        root_r <= '0;
        cnt_r  <= '0;
      end
      ST_SQRT: begin
        rad_r <= rad_r << 2;
        cnt_r <= cnt_r + 7'd1;
        step_r <= 3'd0;
        if (srem_sh >= trial) begin
          srem_r <= srem_sh - trial;
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          srem_r <= srem_sh;
          root_r <= {root_r[30:0], 1'b0};
        end
      end
      ST_DIV_LOAD: begin
        dvd_r  <= vabs[sidx] << UNIT_BITS;
        dvs_r  <= root_r;
        drem_r <= '0;
        quo_r  <= '0;
        cnt_r  <= '0;
      end
      ST_DIV_RUN, ST_VS_RUN: begin
        dvd_r  <= dvd_r << 1;
        quo_r  <= {quo_r[62:0], dbit};
        drem_r <= dbit ? 32'(drem_sh - {1'b0, dvs_r}) : drem_sh[31:0];
        cnt_r  <= cnt_r + 7'd1;
      end
      ST_DIV_STORE: begin
        unique case (nsel_r)
          2'd0:    f_r[sidx] <= vec_r[sidx][63] ? -quo_r[31:0] : quo_r[31:0];
          2'd1:    u_r[sidx] <= vec_r[sidx][63] ? -quo_r[31:0] : quo_r[31:0];
          default: v_r[sidx] <= vec_r[sidx][63] ? -quo_r[31:0] : quo_r[31:0];
        endcase
        step_r <= step_r + 3'd1;
      end
      ST_NRM_DONE: begin
        nsel_r <= nsel_r + 2'd1;
        step_r <= 3'd0;
      end
      ST_CR_ACC: begin
        if (!step_r[0]) vec_r[step_r[2:1]] <= prod_r[63:0];
        else vec_r[step_r[2:1]] <= vec_r[step_r[2:1]] - prod_r[63:0];
        step_r <= step_r + 3'd1;
      end
      ST_VS_LOAD: begin
        vscale_r <= (cfg.width != '0) ? 32'hffff_ffff : 32'd0;
        dvd_r    <= {16'd0, cfg.width, 16'd0};
        dvs_r    <= cfg.aspect;
        drem_r   <= '0;
        quo_r    <= '0;
        cnt_r    <= '0;
        step_r   <= 3'd0;
      end
      ST_VS_STORE: begin
        vscale_r <= (quo_r[63:32] != '0) ? 32'hffff_ffff : quo_r[31:0];
        cnt_r    <= '0;
      end
      ST_FIN_ACC: begin
        unique case (cnt_r[1:0])
          2'd0: centre_r[sidx] <= sat32((comp(cfg.cam_pos, sidx) <<< SH)
                                        + scaled[63:0]);
          2'd1: hstep_r[sidx] <= sat32(scaled[63:0]);
          default: vstep_r[sidx] <= sat32(scaled[63:0]);
        endcase
        if (cnt_r[1:0] == 2'd2) begin
          cnt_r  <= '0;
          step_r <= step_r + 3'd1;
        end else begin
          cnt_r <= cnt_r + 7'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    basis.centre     = centre_r;
    basis.hstep      = hstep_r;
    basis.vstep      = vstep_r;
    basis.degenerate = deg_r;
    basis.busy       = state_r != ST_IDLE;
  end

endmodule

/* design/camera_ray_generator.sv */
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_ready   | in_screen_x, in_screen_y (Q2.14)
// out     | output    | out_valid/out_ready | out_point_*, out_dir_* (Q16.16), out_degenerate
// cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// One beat per cycle through a four-stage pipeline while out_ready is high and no basis rebuild runs.
// After reset and after each register write the screen basis is rebuilt by a
// sequencer with a bit-serial square root and divider, and in_ready stays low
// until it is done; a zero vector skips its normalization.
// Each stage holds its beat while the one after it is full and stalled.
module camera_ray_generator #(
  parameter int COORD_FRAC_BITS = crg_pkg::DEF_COORD_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [15:0]            in_screen_x,
  input  logic signed [15:0]            in_screen_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            out_point_x,
  output logic signed [31:0]            out_point_y,
  output logic signed [31:0]            out_point_z,
  output logic signed [31:0]            out_dir_x,
  output logic signed [31:0]            out_dir_y,
  output logic signed [31:0]            out_dir_z,
  output logic                          out_degenerate,
  input  logic                          cfg_we,
  input  logic [crg_pkg::IDX_W-1:0]     cfg_index,
  input  logic [crg_pkg::CFG_W-1:0]     cfg_data
);
  import crg_pkg::*;

  localparam int SH = 16 - COORD_FRAC_BITS;

  logic [CFG_W-1:0] pos_r, look_r, up_r;
  logic [Q_W-1:0]   focal_r, width_r, aspect_r;
  crg_cfg_t         cfg;
  crg_basis_t       basis;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  logic signed [15:0] x1_r, y1_r;
  logic signed [47:0] ph_r [3];
  logic signed [47:0] pv_r [3];
  logic signed [35:0] p3_r [3];
  logic [Q_W-1:0]     pt_r [3];
  logic [Q_W-1:0]     dr_r [3];
  logic signed [49:0] acc [3];
  logic signed [63:0] pw [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= RST_CAM_POS;
      look_r   <= RST_LOOK_AT;
      up_r     <= RST_UP;
      focal_r  <= RST_FOCAL;
      width_r  <= RST_WIDTH;
      aspect_r <= RST_ASPECT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAM_POS: pos_r    <= cfg_data;
        REG_LOOK_AT: look_r   <= cfg_data;
        REG_UP:      up_r     <= cfg_data;
        REG_FOCAL:   focal_r  <= cfg_data[Q_W-1:0];
        REG_WIDTH:   width_r  <= cfg_data[Q_W-1:0];
        REG_ASPECT:  aspect_r <= cfg_data[Q_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.cam_pos = pos_r;
    cfg.look_at = look_r;
    cfg.up_dir  = up_r;
    cfg.focal   = focal_r;
    cfg.width   = width_r;
    cfg.aspect  = aspect_r;
    cfg.start   = cfg_we && (cfg_index <= REG_ASPECT);
  end

  crg_basis #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_basis (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .basis (basis)
  );

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1 && !basis.busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid && in_ready;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = {{4{basis.centre[i][31]}}, basis.centre[i], 14'd0}
             + {{2{ph_r[i][47]}}, ph_r[i]} + {{2{pv_r[i][47]}}, pv_r[i]};
      pw[i]  = {{28{p3_r[i][35]}}, p3_r[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      x1_r <= in_screen_x;
      y1_r <= in_screen_y;
    end
    for (int i = 0; i < 3; i++) begin
      if (rdy2) begin
        ph_r[i] <= $signed(basis.hstep[i]) * x1_r;
        pv_r[i] <= $signed(basis.vstep[i]) * y1_r;
      end
      // floor shift back to Q16.16
      if (rdy3) p3_r[i] <= acc[i][49:14];
      if (rdy4) begin
        pt_r[i] <= sat32(pw[i]);
        dr_r[i] <= sat32(pw[i] - (comp(pos_r, 2'(i)) <<< SH));
      end
    end
  end

  assign out_valid      = v4_r;
  assign out_point_x    = pt_r[0];
  assign out_point_y    = pt_r[1];
  assign out_point_z    = pt_r[2];
  assign out_dir_x      = dr_r[0];
  assign out_dir_y      = dr_r[1];
  assign out_dir_z      = dr_r[2];
  assign out_degenerate = basis.degenerate;

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.start |=> !in_ready)
    else $error("input taken right after a register write");

  a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !rdy2) |=> (v1_r && $stable(x1_r) && $stable(y1_r)))
    else $error("stage one beat lost under stall");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    basis.busy |-> !(in_valid && in_ready))
    else $error("input accepted while basis rebuild runs");

endmodule
